### src/stp_pkg.sv
// Shared constants, codes and types of the soft timer pool.
// No dependencies; every other file of the block refers to it by scoped names.
package stp_pkg;

    // Payload widths
    localparam int OP_W       = 3;
    localparam int SLOT_ID_W  = 3;
    localparam int UNIT_W     = 2;
    localparam int VAL_W      = 64;
    localparam int CNT_IN_W   = 32;
    localparam int CLK_W      = 30;
    localparam int WRAP_W     = 32;
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 32;

    // Defaults of the top-level parameters
    localparam int DEFAULT_SLOTS      = 8;
    localparam int DEFAULT_COUNT_BITS = 32;

    // Operation codes
    localparam logic [OP_W-1:0] OP_ACQUIRE = 3'd0;
    localparam logic [OP_W-1:0] OP_RELEASE = 3'd1;
    localparam logic [OP_W-1:0] OP_ELAPSED = 3'd2;
    localparam logic [OP_W-1:0] OP_TIMEOUT = 3'd3;
    localparam logic [OP_W-1:0] OP_TICK    = 3'd4;

    // Unit codes
    localparam logic [UNIT_W-1:0] UNIT_COUNTS = 2'd0;
    localparam logic [UNIT_W-1:0] UNIT_US     = 2'd1;
    localparam logic [UNIT_W-1:0] UNIT_MS     = 2'd2;
    localparam logic [UNIT_W-1:0] UNIT_S      = 2'd3;

    // Register indexes and reset values
    localparam logic [CFG_IDX_W-1:0] CFG_CLOCK_HZ = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_COUNT_UP = 8'd1;
    localparam logic [CLK_W-1:0]     CLOCK_HZ_RESET = 30'd1000000;

    // Unit scaling, walked MSB first by the shift-add multiply
    localparam int               MUL_W     = 20;
    localparam int               MUL_IDX_W = $clog2(MUL_W);
    localparam logic [MUL_W-1:0] SCALE_US  = 20'd1000000;
    localparam logic [MUL_W-1:0] SCALE_MS  = 20'd1000;

    // Restoring divide: one quotient bit per step
    localparam int DIV_STEPS = VAL_W;
    localparam int STEP_W    = $clog2(DIV_STEPS);

    // Shared adder/subtractor
    typedef struct packed {
        logic [VAL_W-1:0] a;
        logic [VAL_W-1:0] b;
        logic             sub;
    } alu_req_t;

    typedef struct packed {
        logic [VAL_W-1:0] sum;
        logic             carry;   // on subtract: a >= b
    } alu_rsp_t;

endpackage

### src/stp_if.sv
// Handshake channels of the soft timer pool: command, response, config write.
// Depends on stp_pkg for payload widths.
interface stp_cmd_if;
    logic                           valid;
    logic                           ready;
    logic [stp_pkg::OP_W-1:0]       operation;
    logic [stp_pkg::SLOT_ID_W-1:0]  slot_id;
    logic [stp_pkg::UNIT_W-1:0]     unit;
    logic [stp_pkg::VAL_W-1:0]      threshold;
    logic [stp_pkg::CNT_IN_W-1:0]   current_count;

    modport source (output valid, operation, slot_id, unit, threshold, current_count,
                    input ready);
    modport sink   (input valid, operation, slot_id, unit, threshold, current_count,
                    output ready);
endinterface

interface stp_rsp_if;
    logic                           valid;
    logic                           ready;
    logic [stp_pkg::SLOT_ID_W-1:0]  granted_slot;
    logic                           acquire_failed;
    logic [stp_pkg::VAL_W-1:0]      elapsed;
    logic                           timed_out;

    modport source (output valid, granted_slot, acquire_failed, elapsed, timed_out,
                    input ready);
    modport sink   (input valid, granted_slot, acquire_failed, elapsed, timed_out,
                    output ready);
endinterface

interface stp_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [stp_pkg::CFG_IDX_W-1:0]   index;
    logic [stp_pkg::CFG_DATA_W-1:0]  data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

### src/stp_alu.sv
// Shared 64-bit adder/subtractor used by most arithmetic steps of the sequencer.
// Depends on stp_pkg for the request and response structs.
module stp_alu
(
    input  stp_pkg::alu_req_t req,
    output stp_pkg::alu_rsp_t rsp
);

    logic [stp_pkg::VAL_W-1:0] b_op;

    assign b_op = req.sub ? ~req.b : req.b;
    assign {rsp.carry, rsp.sum} = {1'b0, req.a} + {1'b0, b_op}
                                  + (stp_pkg::VAL_W+1)'(req.sub);

endmodule

### src/stp_store.sv
// Per-slot storage: counter snapshot and tick mark taken at acquire.
// Depends on stp_pkg for the tick mark width; registered read.
module stp_store
#(
    parameter int SLOTS      = stp_pkg::DEFAULT_SLOTS,
    parameter int COUNT_BITS = stp_pkg::DEFAULT_COUNT_BITS
)
(
    input  logic                                    clk,
    input  logic                                    we,
    input  logic [((SLOTS > 1) ? $clog2(SLOTS) : 1)-1:0] waddr,
    input  logic [COUNT_BITS+stp_pkg::WRAP_W-1:0]   wdata,
    input  logic [((SLOTS > 1) ? $clog2(SLOTS) : 1)-1:0] raddr,
    output logic [COUNT_BITS+stp_pkg::WRAP_W-1:0]   rdata
);

    logic [COUNT_BITS+stp_pkg::WRAP_W-1:0] mem [SLOTS];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

### src/soft_timer_pool.sv
// Soft timer pool top level: slot bookkeeping, sequencer and result register.
// Depends on stp_pkg, the stp_if channels, stp_alu and stp_store.
//
//  channel | dir | carries                                              | transfer
//  --------+-----+------------------------------------------------------+-----------------
//  cmd     | in  | operation, slot_id, unit, threshold, current_count   | valid & ready
//  rsp     | out | granted_slot, acquire_failed, elapsed, timed_out     | valid & ready
//  cfg     | in  | index (0 clock_hz, 1 count_up), data                 | valid & ready
//
// Release, overflow tick and unknown codes finish in the idle state. Acquire scans the
// running flags one slot per cycle. A query of an idle slot goes straight to the result;
// a live query reads the store, forms the count difference and wrap count, then in us or
// ms runs 20 shift-add multiply steps and 64 restoring divide steps, in seconds only the
// divide steps, all through the one shared 64-bit adder. cmd.ready is high only while the
// sequencer is idle; a result waiting in the output register does not block the next
// transfer in, only the hand-off of the following result. cfg is always ready. Reset:
// all slots idle, clock_hz 1000000, count up.
module soft_timer_pool
#(
    parameter int SLOTS      = stp_pkg::DEFAULT_SLOTS,
    parameter int COUNT_BITS = stp_pkg::DEFAULT_COUNT_BITS
)
(
    input  logic          clk,
    input  logic          rst_n,
    stp_cmd_if.sink       cmd,
    stp_rsp_if.source     rsp,
    stp_cfg_if.sink       cfg
);

    localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int MEM_W  = COUNT_BITS + stp_pkg::WRAP_W;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SCAN,
        S_READ,
        S_DIFF,
        S_WRAP,
        S_DEC,
        S_MUL,
        S_DIV,
        S_CMP,
        S_OUT
    } state_t;

    state_t state_reg;

    // Configuration
    logic [stp_pkg::CLK_W-1:0] clock_hz_reg;
    logic                      count_up_reg;

    // Slot bookkeeping. Overflow counts are kept as a global tick count; a slot
    // stores the tick count at acquire and its wraps are the difference.
    logic [SLOTS-1:0]           running_reg;
    logic [stp_pkg::WRAP_W-1:0] tick_reg;

    // Latched command
    logic [stp_pkg::OP_W-1:0]     op_reg;
    logic [SLOT_W-1:0]            slot_reg;
    logic [stp_pkg::UNIT_W-1:0]   unit_reg;
    logic [stp_pkg::VAL_W-1:0]    thr_reg;
    logic [COUNT_BITS-1:0]        cur_reg;

    // Working registers
    logic [SLOT_W-1:0]              scan_reg;
    logic [stp_pkg::STEP_W-1:0]     step_reg;
    logic [COUNT_BITS-1:0]          diff_reg;
    logic                           borrow_reg;
    logic [stp_pkg::WRAP_W-1:0]     wraps_reg;
    logic [stp_pkg::VAL_W-1:0]      acc_reg;
    logic [stp_pkg::VAL_W-1:0]      x_reg;
    logic [stp_pkg::CLK_W-1:0]      rem_reg;
    logic [stp_pkg::SLOT_ID_W-1:0]  granted_reg;
    logic                           failed_reg;
    logic                           tout_reg;

    // Result register
    logic                           rsp_valid_reg;
    logic [stp_pkg::SLOT_ID_W-1:0]  rsp_granted_reg;
    logic                           rsp_failed_reg;
    logic [stp_pkg::VAL_W-1:0]      rsp_elapsed_reg;
    logic                           rsp_tout_reg;

    // Shared unit and storage
    stp_pkg::alu_req_t alu_req;
    stp_pkg::alu_rsp_t alu_rsp;
    logic              mem_we;
    logic [MEM_W-1:0]  mem_wdata;
    logic [MEM_W-1:0]  mem_rdata;
    logic [COUNT_BITS-1:0]      start_cnt;
    logic [stp_pkg::WRAP_W-1:0] start_mark;

    logic [SLOT_W-1:0]          cmd_slot;
    logic                       cmd_live;
    logic [stp_pkg::CLK_W-1:0]  clk_div;
    logic [stp_pkg::CLK_W:0]    rem_shift;
    logic [stp_pkg::MUL_W-1:0]  scale;
    logic [stp_pkg::WRAP_W-1:0] wrap_sel;
    logic [stp_pkg::VAL_W-1:0]  raw_elapsed;
    logic                       out_free;

    assign cmd_slot = SLOT_W'(cmd.slot_id);
    assign cmd_live = (32'(cmd.slot_id) < SLOTS) && running_reg[cmd_slot];

    assign start_cnt  = mem_rdata[MEM_W-1:stp_pkg::WRAP_W];
    assign start_mark = mem_rdata[stp_pkg::WRAP_W-1:0];

    // clock_hz of zero counts as one
    assign clk_div   = (clock_hz_reg == '0) ? stp_pkg::CLK_W'(1) : clock_hz_reg;
    assign rem_shift = {rem_reg, acc_reg[stp_pkg::VAL_W-1]};
    assign scale     = (unit_reg == stp_pkg::UNIT_US) ? stp_pkg::SCALE_US
                                                      : stp_pkg::SCALE_MS;

    // Wrap count after the optional take-back, joined above the count difference
    assign wrap_sel    = (state_reg == S_DEC) ? alu_rsp.sum[stp_pkg::WRAP_W-1:0]
                                              : alu_rsp.sum[stp_pkg::WRAP_W-1:0];
    assign raw_elapsed = (stp_pkg::VAL_W'(wrap_sel) << COUNT_BITS)
                         | stp_pkg::VAL_W'(diff_reg);

    assign out_free = !rsp_valid_reg || rsp.ready;

    assign mem_we    = (state_reg == S_SCAN) && !running_reg[scan_reg];
    assign mem_wdata = {cur_reg, tick_reg};

    stp_store #(
        .SLOTS      (SLOTS),
        .COUNT_BITS (COUNT_BITS)
    ) u_store (
        .clk   (clk),
        .we    (mem_we),
        .waddr (scan_reg),
        .wdata (mem_wdata),
        .raddr (slot_reg),
        .rdata (mem_rdata)
    );

    stp_alu u_alu (
        .req (alu_req),
        .rsp (alu_rsp)
    );

    // Operand selection for the shared adder
    always_comb
    begin
        alu_req = '0;
        unique case (state_reg)
            S_DIFF:
            begin
                // up: cur - start, down: start - cur; borrow marks counter behind
                alu_req.a   = count_up_reg ? stp_pkg::VAL_W'(cur_reg)
                                           : stp_pkg::VAL_W'(start_cnt);
                alu_req.b   = count_up_reg ? stp_pkg::VAL_W'(start_cnt)
                                           : stp_pkg::VAL_W'(cur_reg);
                alu_req.sub = 1'b1;
            end
            S_WRAP:
            begin
                alu_req.a   = stp_pkg::VAL_W'(tick_reg);
                alu_req.b   = stp_pkg::VAL_W'(start_mark);
                alu_req.sub = 1'b1;
            end
            S_DEC:
            begin
                alu_req.a   = stp_pkg::VAL_W'(wraps_reg);
                alu_req.b   = stp_pkg::VAL_W'(1);
                alu_req.sub = 1'b1;
            end
            S_MUL:
            begin
                alu_req.a = acc_reg << 1;
                alu_req.b = scale[step_reg[stp_pkg::MUL_IDX_W-1:0]] ? x_reg : '0;
            end
            S_DIV:
            begin
                alu_req.a   = stp_pkg::VAL_W'(rem_shift);
                alu_req.b   = stp_pkg::VAL_W'(clk_div);
                alu_req.sub = 1'b1;
            end
            S_CMP:
            begin
                alu_req.a   = acc_reg;
                alu_req.b   = thr_reg;
                alu_req.sub = 1'b1;
            end
            default:
            begin
                alu_req = '0;
            end
        endcase
    end

    assign cmd.ready = (state_reg == S_IDLE);
    assign cfg.ready = 1'b1;

    assign rsp.valid          = rsp_valid_reg;
    assign rsp.granted_slot   = rsp_granted_reg;
    assign rsp.acquire_failed = rsp_failed_reg;
    assign rsp.elapsed        = rsp_elapsed_reg;
    assign rsp.timed_out      = rsp_tout_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            clock_hz_reg    <= stp_pkg::CLOCK_HZ_RESET;
            count_up_reg    <= 1'b1;
            running_reg     <= '0;
            tick_reg        <= '0;
            op_reg          <= '0;
            slot_reg        <= '0;
            unit_reg        <= '0;
            thr_reg         <= '0;
            cur_reg         <= '0;
            scan_reg        <= '0;
            step_reg        <= '0;
            diff_reg        <= '0;
            borrow_reg      <= 1'b0;
            wraps_reg       <= '0;
            acc_reg         <= '0;
            x_reg           <= '0;
            rem_reg         <= '0;
            granted_reg     <= '0;
            failed_reg      <= 1'b0;
            tout_reg        <= 1'b0;
            rsp_valid_reg   <= 1'b0;
            rsp_granted_reg <= '0;
            rsp_failed_reg  <= 1'b0;
            rsp_elapsed_reg <= '0;
            rsp_tout_reg    <= 1'b0;
        end
        else
        begin
            // Config writes are to arrive only while idle; the block itself does not enforce it
            if (cfg.valid)
            begin
                if (cfg.index == stp_pkg::CFG_CLOCK_HZ)
                begin
                    clock_hz_reg <= cfg.data[stp_pkg::CLK_W-1:0];
                end
                else if (cfg.index == stp_pkg::CFG_COUNT_UP)
                begin
                    count_up_reg <= cfg.data[0];
                end
            end

            // Result hand-off
            if (state_reg == S_OUT && out_free)
            begin
                rsp_valid_reg   <= 1'b1;
                rsp_granted_reg <= granted_reg;
                rsp_failed_reg  <= failed_reg;
                rsp_elapsed_reg <= acc_reg;
                rsp_tout_reg    <= tout_reg;
            end
            else if (rsp.ready)
            begin
                rsp_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    if (cmd.valid)
                    begin
                        op_reg      <= cmd.operation;
                        slot_reg    <= cmd_slot;
                        unit_reg    <= cmd.unit;
                        thr_reg     <= cmd.threshold;
                        cur_reg     <= cmd.current_count[COUNT_BITS-1:0];
                        granted_reg <= '0;
                        failed_reg  <= 1'b0;
                        tout_reg    <= 1'b0;
                        acc_reg     <= '0;
                        scan_reg    <= '0;
                        priority case (cmd.operation)
                            stp_pkg::OP_ACQUIRE:
                            begin
                                state_reg <= S_SCAN;
                            end
                            stp_pkg::OP_RELEASE:
                            begin
                                if (cmd_live)
                                begin
                                    running_reg[cmd_slot] <= 1'b0;
                                end
                            end
                            stp_pkg::OP_ELAPSED, stp_pkg::OP_TIMEOUT:
                            begin
                                if (cmd_live)
                                begin
                                    state_reg <= S_READ;
                                end
                                else
                                begin
                                    // idle slot: elapsed 0, a timeout check is true
                                    tout_reg  <= (cmd.operation == stp_pkg::OP_TIMEOUT);
                                    state_reg <= S_OUT;
                                end
                            end
                            stp_pkg::OP_TICK:
                            begin
                                tick_reg <= tick_reg + stp_pkg::WRAP_W'(1);
                            end
                            default:
                            begin
                                state_reg <= S_IDLE;
                            end
                        endcase
                    end
                end

                S_SCAN:
                begin
                    if (!running_reg[scan_reg])
                    begin
                        running_reg[scan_reg] <= 1'b1;
                        granted_reg           <= stp_pkg::SLOT_ID_W'(scan_reg);
                        state_reg             <= S_OUT;
                    end
                    else if (scan_reg == SLOT_W'(SLOTS - 1))
                    begin
                        failed_reg <= 1'b1;
                        state_reg  <= S_OUT;
                    end
                    else
                    begin
                        scan_reg <= scan_reg + SLOT_W'(1);
                    end
                end

                S_READ:
                begin
                    state_reg <= S_DIFF;
                end

                S_DIFF:
                begin
                    diff_reg   <= alu_rsp.sum[COUNT_BITS-1:0];
                    borrow_reg <= !alu_rsp.carry;
                    state_reg  <= S_WRAP;
                end

                S_WRAP, S_DEC:
                begin
                    if (state_reg == S_WRAP && borrow_reg
                        && alu_rsp.sum[stp_pkg::WRAP_W-1:0] != '0)
                    begin
                        // counter not yet past the snapshot: take one wrap back
                        wraps_reg <= alu_rsp.sum[stp_pkg::WRAP_W-1:0];
                        state_reg <= S_DEC;
                    end
                    else
                    begin
                        x_reg <= raw_elapsed;
                        priority case (unit_reg)
                            stp_pkg::UNIT_COUNTS:
                            begin
                                acc_reg   <= raw_elapsed;
                                state_reg <= (op_reg == stp_pkg::OP_TIMEOUT) ? S_CMP : S_OUT;
                            end
                            stp_pkg::UNIT_S:
                            begin
                                acc_reg   <= raw_elapsed;
                                rem_reg   <= '0;
                                step_reg  <= stp_pkg::STEP_W'(stp_pkg::DIV_STEPS - 1);
                                state_reg <= S_DIV;
                            end
                            default:
                            begin
                                acc_reg   <= '0;
                                step_reg  <= stp_pkg::STEP_W'(stp_pkg::MUL_W - 1);
                                state_reg <= S_MUL;
                            end
                        endcase
                    end
                end

                S_MUL:
                begin
                    // product wraps at 64 bits
                    acc_reg <= alu_rsp.sum;
                    if (step_reg == '0)
                    begin
                        rem_reg   <= '0;
                        step_reg  <= stp_pkg::STEP_W'(stp_pkg::DIV_STEPS - 1);
                        state_reg <= S_DIV;
                    end
                    else
                    begin
                        step_reg <= step_reg - stp_pkg::STEP_W'(1);
                    end
                end

                S_DIV:
                begin
                    if (alu_rsp.carry)
                    begin
                        rem_reg <= alu_rsp.sum[stp_pkg::CLK_W-1:0];
                        acc_reg <= {acc_reg[stp_pkg::VAL_W-2:0], 1'b1};
                    end
                    else
                    begin
                        rem_reg <= rem_shift[stp_pkg::CLK_W-1:0];
                        acc_reg <= {acc_reg[stp_pkg::VAL_W-2:0], 1'b0};
                    end
                    if (step_reg == '0)
                    begin
                        state_reg <= (op_reg == stp_pkg::OP_TIMEOUT) ? S_CMP : S_OUT;
                    end
                    else
                    begin
                        step_reg <= step_reg - stp_pkg::STEP_W'(1);
                    end
                end

                S_CMP:
                begin
                    tout_reg  <= alu_rsp.carry;
                    state_reg <= S_OUT;
                end

                S_OUT:
                begin
                    if (out_free)
                    begin
                        state_reg <= S_IDLE;
                    end
                end

                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule
